>>> rtl/core/a2s_pkg.sv
`timescale 1ns / 1ps

package a2s_pkg;

  // Datapath widths. Angles and ratios are Q2.30 internally.
  localparam int RATIO_W = 31;
  localparam int MAG_W   = 29;
  localparam int T2_W    = 28;
  localparam int SER_W   = 31;
  localparam int PROD_W  = 29;
  localparam int R_W     = 34;
  localparam int ANGLE_W = 23;
  localparam int NUM2_W  = 60;
  localparam int DEN2_W  = 32;
  localparam int QFRAC   = 30;

  localparam logic [63:0] HALF_LSB = 64'd1 << (QFRAC - 1);

  localparam logic [RATIO_W-1:0] ONE_Q30   = 31'd1073741824;
  localparam logic [RATIO_W-1:0] SQRT3_Q30 = 31'd1859775393;
  localparam logic [RATIO_W-1:0] TAN15_Q30 = 31'd287708255;
  localparam logic [62:0]        ONE_Q60   = 63'd1 << 60;

  localparam logic signed [R_W-1:0] PI_Q30       = 34'sd3373259426;
  localparam logic signed [R_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [R_W-1:0] SIXTH_PI_Q30 = 34'sd562209904;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 23'sd3294199;

  // Quadrant bookkeeping that travels with every transaction.
  typedef struct packed {
    logic zero;
    logic yneg;
    logic xneg;
    logic swap;
  } quad_t;

  // Sideband through the reduction divider.
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               big;
    logic               nneg;
    quad_t              q;
  } red_side_t;

  // Sideband through the series evaluator.
  typedef struct packed {
    logic  big;
    logic  neg;
    quad_t q;
  } ser_side_t;

endpackage

>>> rtl/core/atan2_series_eval_core.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while out_stall is low; the two
// 1-bit-per-stage dividers and the one-term-per-stage series pipeline set
// the depth, not the rate.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
// A stall only holds stages that are full, so bubbles are squeezed out.

module atan2_series_eval_core #(
  parameter int INPUT_WIDTH            = 24,
  parameter int SERIES_TOP_DENOMINATOR = 17
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [INPUT_WIDTH-1:0]         in_y_value,
  input  logic signed [INPUT_WIDTH-1:0]         in_x_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [a2s_pkg::ANGLE_W-1:0]    out_angle
);

  import a2s_pkg::*;

  localparam int W      = INPUT_WIDTH;
  localparam int TOP    = SERIES_TOP_DENOMINATOR | 1;
  localparam int NUM1_W = W + 31;
  localparam int QW_B   = $bits(quad_t);
  localparam int RS_B   = $bits(red_side_t);

  // Stage 1 takes magnitudes and records the signs and the both-zero case.
  logic         s1_v_r;
  logic [W-1:0] s1_ax_r;
  logic [W-1:0] s1_ay_r;
  quad_t        s1_q_r;
  logic         s1_load;
  logic         s2_hold;

  assign s1_load  = !s1_v_r || !s2_hold;
  assign in_stall = s1_v_r && s2_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ax_r     <= in_x_value[W-1] ? (~$unsigned(in_x_value) + W'(1)) : $unsigned(in_x_value);
      s1_ay_r     <= in_y_value[W-1] ? (~$unsigned(in_y_value) + W'(1)) : $unsigned(in_y_value);
      s1_q_r.zero <= (in_x_value == '0) && (in_y_value == '0);
      s1_q_r.yneg <= in_y_value[W-1];
      s1_q_r.xneg <= in_x_value[W-1];
      s1_q_r.swap <= 1'b0;
    end
  end

  // Stage 2 orders the magnitudes and forms the rounded ratio numerator.
  logic              s2_v_r;
  logic [NUM1_W-1:0] s2_num_r;
  logic [W-1:0]      s2_hi_r;
  quad_t             s2_q_r;
  logic              s2_load;
  logic              swap;
  logic [W-1:0]      lo;
  logic [W-1:0]      hi;
  logic              d1_in_stall;

  assign swap    = s1_ay_r > s1_ax_r;
  assign lo      = swap ? s1_ax_r : s1_ay_r;
  assign hi      = swap ? s1_ay_r : s1_ax_r;
  assign s2_load = !s2_v_r || !d1_in_stall;
  assign s2_hold = s2_v_r && d1_in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_num_r <= NUM1_W'({lo, 30'b0}) + NUM1_W'(hi >> 1);
      s2_hi_r  <= hi;
      s2_q_r   <= '{zero: s1_q_r.zero, yneg: s1_q_r.yneg, xneg: s1_q_r.xneg, swap: swap};
    end
  end

  // Ratio of the smaller magnitude to the larger, Q2.30 in [0, 1].
  logic               d1_valid;
  logic [RATIO_W-1:0] d1_quo;
  logic [QW_B-1:0]    d1_side_bits;
  quad_t              d1_side;
  logic               s3_hold;

  a2s_div #(
    .NUM_W (NUM1_W),
    .DEN_W (W),
    .QW    (RATIO_W),
    .SB_W  (QW_B)
  ) u_ratio_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_stall  (d1_in_stall),
    .in_num    (s2_num_r),
    .in_den    (s2_hi_r),
    .in_side   (s2_q_r),
    .out_valid (d1_valid),
    .out_stall (s3_hold),
    .out_quo   (d1_quo),
    .out_side  (d1_side_bits)
  );

  assign d1_side = quad_t'(d1_side_bits);

  // Stage 3 decides on range reduction and multiplies the ratio by sqrt(3).
  logic               s3_v_r;
  logic [61:0]        s3_prod_r;
  logic [RATIO_W-1:0] s3_ratio_r;
  logic               s3_big_r;
  quad_t              s3_q_r;
  logic               s3_load;
  logic               s4_hold;

  assign s3_load = !s3_v_r || !s4_hold;
  assign s3_hold = s3_v_r && s4_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_load) begin
      s3_v_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_prod_r  <= d1_quo * SQRT3_Q30;
      s3_ratio_r <= d1_quo;
      s3_big_r   <= d1_quo > TAN15_Q30;
      s3_q_r     <= d1_side;
    end
  end

  // Stage 4 forms |sqrt3*a - 1| and a + sqrt3 for the reduction divide. The
  // quotient is truncated toward zero, so the sign is carried separately.
  logic              s4_v_r;
  logic [NUM2_W-1:0] s4_num_r;
  logic [DEN2_W-1:0] s4_den_r;
  red_side_t         s4_side_r;
  logic              s4_load;
  logic [62:0]       num;
  logic [62:0]       nabs;
  logic              d2_in_stall;

  assign num     = {1'b0, s3_prod_r} - ONE_Q60;
  assign nabs    = num[62] ? (~num + 63'd1) : num;
  assign s4_load = !s4_v_r || !d2_in_stall;
  assign s4_hold = s4_v_r && d2_in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_load) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_load) begin
      s4_num_r        <= s3_big_r ? nabs[NUM2_W-1:0] : '0;
      s4_den_r        <= DEN2_W'(s3_ratio_r) + DEN2_W'(SQRT3_Q30);
      s4_side_r.ratio <= s3_ratio_r;
      s4_side_r.big   <= s3_big_r;
      s4_side_r.nneg  <= num[62];
      s4_side_r.q     <= s3_q_r;
    end
  end

  // Reduced argument magnitude.
  logic             d2_valid;
  logic [MAG_W-1:0] d2_quo;
  logic [RS_B-1:0]  d2_side_bits;
  red_side_t        d2_side;
  logic             sr_in_stall;

  a2s_div #(
    .NUM_W (NUM2_W),
    .DEN_W (DEN2_W),
    .QW    (MAG_W),
    .SB_W  (RS_B)
  ) u_reduce_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_v_r),
    .in_stall  (d2_in_stall),
    .in_num    (s4_num_r),
    .in_den    (s4_den_r),
    .in_side   (s4_side_r),
    .out_valid (d2_valid),
    .out_stall (sr_in_stall),
    .out_quo   (d2_quo),
    .out_side  (d2_side_bits)
  );

  assign d2_side = red_side_t'(d2_side_bits);

  // Pick the reduced or the plain ratio for the series.
  logic [MAG_W-1:0]  sr_mag;
  ser_side_t         sr_in_side;
  logic              sr_valid;
  logic [PROD_W-1:0] sr_prod;
  ser_side_t         sr_side;
  logic              s6_hold;

  assign sr_mag         = d2_side.big ? d2_quo : d2_side.ratio[MAG_W-1:0];
  assign sr_in_side.big = d2_side.big;
  assign sr_in_side.neg = d2_side.big && d2_side.nneg;
  assign sr_in_side.q   = d2_side.q;

  a2s_series #(
    .TOP (TOP)
  ) u_series (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_valid),
    .in_stall  (sr_in_stall),
    .in_mag    (sr_mag),
    .in_side   (sr_in_side),
    .out_valid (sr_valid),
    .out_stall (s6_hold),
    .out_prod  (sr_prod),
    .out_side  (sr_side)
  );

  // Stage 6 adds the pi/6 offset and reflects by the swap flag and the sign of x.
  logic                  s6_v_r;
  logic signed [R_W-1:0] s6_r_r;
  quad_t                 s6_q_r;
  logic                  s6_load;
  logic signed [R_W-1:0] off;
  logic signed [R_W-1:0] prod_s;
  logic signed [R_W-1:0] r0;
  logic signed [R_W-1:0] r1;
  logic signed [R_W-1:0] r2;
  logic                  s7_hold;

  assign off     = sr_side.big ? SIXTH_PI_Q30 : '0;
  assign prod_s  = $signed(R_W'(sr_prod));
  assign r0      = sr_side.neg ? (off - prod_s) : (off + prod_s);
  assign r1      = sr_side.q.swap ? (HALF_PI_Q30 - r0) : r0;
  assign r2      = sr_side.q.xneg ? (PI_Q30 - r1) : r1;
  assign s6_load = !s6_v_r || !s7_hold;
  assign s6_hold = s6_v_r && s7_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (s6_load) begin
      s6_v_r <= sr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_load) begin
      s6_r_r <= r2;
      s6_q_r <= sr_side.q;
    end
  end

  // Stage 7 is the output register: clamp at zero, round to Q3.20 with halves
  // away from zero, apply the sign of y, and force zero for the origin.
  logic                      s7_v_r;
  logic signed [ANGLE_W-1:0] s7_angle_r;
  logic                      s7_load;
  logic [R_W-1:0]            rr;
  logic [ANGLE_W-1:0]        amag;

  assign rr      = (s6_r_r[R_W-1] ? R_W'(0) : $unsigned(s6_r_r)) + R_W'(512);
  assign amag    = {1'b0, rr[ANGLE_W+8:10]};
  assign s7_load = !s7_v_r || !out_stall;
  assign s7_hold = s7_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (s7_load) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_load) begin
      if (s6_q_r.zero) begin
        s7_angle_r <= '0;
      end else if (s6_q_r.yneg) begin
        s7_angle_r <= $signed(~amag + ANGLE_W'(1));
      end else begin
        s7_angle_r <= $signed(amag);
      end
    end
  end

  assign out_valid = s7_v_r;
  assign out_angle = s7_angle_r;

  // The input is held back only when the whole pipeline is full and the
  // output transaction is blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

  // The ratio of the smaller to the larger magnitude never exceeds one.
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    (d1_valid && !d1_side.zero) |-> (d1_quo <= ONE_Q30))
    else $error("ratio above one");

  // Every delivered angle lies within plus or minus pi.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_angle <= ANGLE_MAX) && (out_angle >= -ANGLE_MAX)))
    else $error("angle outside plus or minus pi");

endmodule

>>> rtl/core/a2s_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The numerator must be below den << QW.
module a2s_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 32,
  parameter int QW    = 29,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_side,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [QW-1:0]    out_quo,
  output logic [SB_W-1:0]  out_side
);

  logic             v   [0:QW];
  logic             stl [0:QW];
  logic [NUM_W-1:0] rem [0:QW-1];
  logic [DEN_W-1:0] den [0:QW-1];
  logic [QW-1:0]    quo [0:QW];
  logic [SB_W-1:0]  sb  [0:QW];

  assign v[0]    = in_valid;
  assign rem[0]  = in_num;
  assign den[0]  = in_den;
  assign quo[0]  = '0;
  assign sb[0]   = in_side;
  assign stl[QW] = out_stall;
  assign in_stall = stl[0];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic             v_r;
    logic [QW-1:0]    quo_r;
    logic [SB_W-1:0]  sb_r;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    logic             load;

    assign dsh  = NUM_W'(den[s]) << B;
    assign ge   = rem[s] >= dsh;
    assign load = !v_r || !stl[s+1];
    assign stl[s] = v_r && stl[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (load) begin
        v_r <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        quo_r <= quo[s] | (ge ? (QW'(1) << B) : QW'(0));
        sb_r  <= sb[s];
      end
    end

    assign v[s+1]   = v_r;
    assign quo[s+1] = quo_r;
    assign sb[s+1]  = sb_r;

    if (s < QW - 1) begin : g_fwd
      logic [NUM_W-1:0] rem_r;
      logic [DEN_W-1:0] den_r;
      always_ff @(posedge clk) begin
        if (load) begin
          rem_r <= ge ? (rem[s] - dsh) : rem[s];
          den_r <= den[s];
        end
      end
      assign rem[s+1] = rem_r;
      assign den[s+1] = den_r;
    end
  end

  assign out_valid = v[QW];
  assign out_quo   = quo[QW];
  assign out_side  = sb[QW];

endmodule

>>> rtl/core/a2s_series.sv
`timescale 1ns / 1ps

// Odd arctangent series, Horner form: a squaring stage, one term per stage, then
// the final product with the reduced argument.
module a2s_series #(
  parameter int TOP = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [a2s_pkg::MAG_W-1:0]      in_mag,
  input  a2s_pkg::ser_side_t             in_side,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [a2s_pkg::PROD_W-1:0]     out_prod,
  output a2s_pkg::ser_side_t             out_side
);

  import a2s_pkg::*;

  localparam int NT = (TOP - 1) / 2;
  localparam int PW = T2_W + SER_W;
  localparam int FW = MAG_W + SER_W;
  localparam longint unsigned SEED_L = ((64'd1 << QFRAC) + TOP / 2) / TOP;
  localparam logic [SER_W-1:0] SEED = SER_W'(SEED_L);

  // Squaring stage.
  logic                  a_v_r;
  logic [MAG_W-1:0]      a_mag_r;
  logic [T2_W-1:0]       a_t2_r;
  ser_side_t             a_side_r;
  logic [2*MAG_W-1:0]    sq;
  logic                  a_load;

  logic             v    [0:NT];
  logic             stl  [0:NT];
  logic [SER_W-1:0] ser  [0:NT];
  logic [T2_W-1:0]  t2   [0:NT-1];
  logic [MAG_W-1:0] mag  [0:NT];
  ser_side_t        side [0:NT];

  assign sq     = in_mag * in_mag + (2*MAG_W)'(HALF_LSB);
  assign a_load = !a_v_r || !stl[0];
  assign in_stall = a_v_r && stl[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_load) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_mag_r  <= in_mag;
      a_t2_r   <= sq[2*MAG_W-1:QFRAC];
      a_side_r <= in_side;
    end
  end

  assign v[0]    = a_v_r;
  assign ser[0]  = SEED;
  assign t2[0]   = a_t2_r;
  assign mag[0]  = a_mag_r;
  assign side[0] = a_side_r;

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int K = TOP - 2 - 2 * j;
    localparam longint unsigned RL = ((64'd1 << QFRAC) + K / 2) / K;
    localparam logic [SER_W-1:0] RECIP = SER_W'(RL);
    logic             v_r;
    logic [SER_W-1:0] ser_r;
    logic [MAG_W-1:0] mag_r;
    ser_side_t        side_r;
    logic [PW-1:0]    pr;
    logic [SER_W-1:0] sub;
    logic             load;

    assign pr   = t2[j] * ser[j] + PW'(HALF_LSB);
    assign sub  = SER_W'(pr[PW-1:QFRAC]);
    assign load = !v_r || !stl[j+1];
    assign stl[j] = v_r && stl[j+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (load) begin
        v_r <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        ser_r  <= (RECIP >= sub) ? (RECIP - sub) : '0;
        mag_r  <= mag[j];
        side_r <= side[j];
      end
    end

    assign v[j+1]    = v_r;
    assign ser[j+1]  = ser_r;
    assign mag[j+1]  = mag_r;
    assign side[j+1] = side_r;

    if (j < NT - 1) begin : g_fwd
      logic [T2_W-1:0] t2_r;
      always_ff @(posedge clk) begin
        if (load) begin
          t2_r <= t2[j];
        end
      end
      assign t2[j+1] = t2_r;
    end
  end

  // Final product with the reduced argument.
  logic              f_v_r;
  logic [PROD_W-1:0] f_prod_r;
  ser_side_t         f_side_r;
  logic [FW-1:0]     pf;
  logic              f_load;

  assign pf      = mag[NT] * ser[NT] + FW'(HALF_LSB);
  assign f_load  = !f_v_r || !out_stall;
  assign stl[NT] = f_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_load) begin
      f_v_r <= v[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      f_prod_r <= pf[QFRAC+PROD_W-1:QFRAC];
      f_side_r <= side[NT];
    end
  end

  assign out_valid = f_v_r;
  assign out_prod  = f_prod_r;
  assign out_side  = f_side_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import a2s_pkg::*;

  localparam int IW       = 24;
  localparam int TOP_DEN  = 17;
  localparam int LATENCY  = 68 + ((TOP_DEN | 1) - 1) / 2;

  // Q2.30 constants used by the angle predictor.
  localparam longint Q_ONE   = 64'd1073741824;
  localparam longint Q_PI    = 64'd3373259426;
  localparam longint Q_HPI   = 64'd1686629713;
  localparam longint Q_SXPI  = 64'd562209904;
  localparam longint Q_SQRT3 = 64'd1859775393;
  localparam longint Q_TAN15 = 64'd287708255;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [IW-1:0] in_y_value;
  logic signed [IW-1:0] in_x_value;
  logic out_valid;
  logic out_stall;
  logic signed [ANGLE_W-1:0] out_angle;

  // Angles predicted for accepted transactions, oldest first.
  logic signed [ANGLE_W-1:0] angle_queue[$];
  int mismatch_count;
  int sent_count;
  int angle_count;
  logic stall_enable;

  atan2_series_eval_core #(
    .INPUT_WIDTH(IW),
    .SERIES_TOP_DENOMINATOR(TOP_DEN)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_y_value(in_y_value),
    .in_x_value(in_x_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_angle(out_angle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounded Q2.30 product of two unsigned values.
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Predicted Q3.20 angle for one coordinate pair. The ratio of the smaller
  // magnitude to the larger is reduced above tan 15 degrees, the odd series is
  // evaluated by Horner's rule, and the quadrant is restored at the end.
  function automatic logic signed [ANGLE_W-1:0] predict_angle(logic signed [IW-1:0] y_in,
                                                              logic signed [IW-1:0] x_in);
    longint y, x, ratio, red, offset, num, den, r;
    longint unsigned ax, ay, lo, hi, mag, t2, series, recip, sub, prod, rmag;
    logic swap, neg;
    int k;
    int top;
    y = y_in;
    x = x_in;
    if (x == 0 && y == 0) return '0;
    top = TOP_DEN | 1;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    swap = ay > ax;
    lo = swap ? ax : ay;
    hi = swap ? ay : ax;
    ratio = ((lo << 30) + hi / 2) / hi;
    offset = 0;
    red = ratio;
    if (ratio > Q_TAN15) begin
      num = Q_SQRT3 * ratio - Q_ONE * Q_ONE;
      den = ratio + Q_SQRT3;
      red = num / den;
      offset = Q_SXPI;
    end
    neg = red < 0;
    mag = neg ? -red : red;
    t2 = q30_mul(mag, mag);
    series = (Q_ONE + top / 2) / top;
    for (k = top - 2; k >= 1; k -= 2) begin
      recip = (Q_ONE + k / 2) / k;
      sub = q30_mul(t2, series);
      series = (recip >= sub) ? recip - sub : 0;
    end
    prod = q30_mul(mag, series);
    r = neg ? offset - longint'(prod) : offset + longint'(prod);
    if (swap) r = Q_HPI - r;
    if (x < 0) r = Q_PI - r;
    if (r < 0) r = 0;
    rmag = (longint'(r) + 512) >> 10;
    return (y < 0) ? -ANGLE_W'(rmag) : ANGLE_W'(rmag);
  endfunction

  task automatic report_mismatch(string what, logic signed [ANGLE_W-1:0] got,
                                 logic signed [ANGLE_W-1:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Mostly short gaps with the occasional long one.
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one transaction, holding it stable until the block accepts it.
  // With no gap, valid stays high and the next transaction follows at once.
  task automatic send_pair(int y, int x);
    int gap;
    in_y_value <= IW'(y);
    in_x_value <= IW'(x);
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    angle_queue.push_back(predict_angle(IW'(y), IW'(x)));
    sent_count++;
    @(negedge clk);
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Result checker: every accepted angle is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      angle_count++;
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected angle", out_angle, '0);
      end else begin
        logic signed [ANGLE_W-1:0] want;
        want = angle_queue.pop_front();
        if (out_angle !== want) report_mismatch("angle", out_angle, want);
      end
    end
  end

  // Receiver back-pressure, with stretches where it is switched off.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_enable) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        hold = gap_cycles() + 1;
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Axes, full-scale extremes, both-zero input and the diagonals.
  task automatic test_directed();
    logic signed [IW-1:0] vmax, vmin;
    vmax = {1'b0, {(IW-1){1'b1}}};
    vmin = {1'b1, {(IW-1){1'b0}}};
    send_pair(0, 0);
    send_pair(0, 1);
    send_pair(0, -1);
    send_pair(1, 0);
    send_pair(-1, 0);
    send_pair(0, vmin);
    send_pair(vmax, 0);
    send_pair(vmin, 0);
    send_pair(vmax, vmax);
    send_pair(vmin, vmin);
    send_pair(vmin, vmax);
    send_pair(vmax, vmin);
    send_pair(vmin, -1);
    send_pair(1, vmin);
    send_pair(-1, vmax);
    send_pair(5, 5);
    send_pair(-5, 5);
    send_pair(5, -5);
    send_pair(-5, -5);
    // Ratios on either side of tan 15 degrees.
    send_pair(2679492, 10000000 / 2);
    send_pair(267949, 1000000);
    send_pair(267950, 1000000);
    send_pair(1000000, 267950);
    send_pair(3, 7);
  endtask

  // Random pairs over the whole range, small magnitudes, axis-near points and diagonals.
  task automatic test_random(int count);
    logic signed [IW-1:0] y, x;
    int mode;
    repeat (count) begin
      mode = $urandom_range(0, 9);
      y = IW'($urandom());
      x = IW'($urandom());
      if (mode == 0) begin
        y = IW'($signed($urandom_range(0, 16)) - 8);
        x = IW'($signed($urandom_range(0, 16)) - 8);
      end else if (mode == 1) begin
        y = IW'($signed($urandom_range(0, 200)) - 100);
      end else if (mode == 2) begin
        x = IW'($signed($urandom_range(0, 200)) - 100);
      end else if (mode == 3) begin
        x = ($urandom_range(0, 1) != 0) ? y : -y;
      end
      send_pair(y, x);
    end
  endtask

  // Back-to-back traffic with the receiver never stalling.
  task automatic test_streaming(int count);
    stall_enable = 1'b0;
    repeat (count) begin
      in_y_value <= IW'($urandom());
      in_x_value <= IW'($urandom());
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      angle_queue.push_back(predict_angle(in_y_value, in_x_value));
      sent_count++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
    stall_enable = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_y_value = '0;
    in_x_value = '0;
    stall_enable = 1'b1;
    mismatch_count = 0;
    sent_count = 0;
    angle_count = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(1000);
    test_streaming(300);

    while (angle_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("Covered %0d coordinate pairs (axes, extremes, all quadrants, random)",
             sent_count);
    $display("Checked %0d angles, %0d mismatches", angle_count, mismatch_count);
    if (mismatch_count == 0 && angle_queue.size() == 0) begin
      $display("atan2_series_eval_core regression: pass");
    end else begin
      $display("atan2_series_eval_core regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout after %0d angles", angle_count);
    $display("atan2_series_eval_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/a2s_pkg.sv
rtl/core/a2s_div.sv
rtl/core/a2s_series.sv
rtl/core/atan2_series_eval_core.sv
tb/tb_top.sv
